// ===== rtl/rgb_pixel_point_operation_core_defines.svh =====
// Assertion macros shared by the checker of the pixel point operation core.
`ifndef RGB_PIXEL_POINT_OPERATION_CORE_DEFINES_SVH
`define RGB_PIXEL_POINT_OPERATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RPPO_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rppo: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RPPO_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rppo: assertion failed");

`endif

// ===== rtl/rppo_pkg.sv =====
// Types, constants and the divider step function of the pixel point operation core.
package rppo_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned PIX_W      = CHAN_W * NUM_CHAN;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned DVSR_W     = 16;
  localparam int unsigned ADD_W      = 9;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PROD_W     = CHAN_W + FACTOR_W;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = PROD_W / DIV_BITS;

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
  localparam logic [DVSR_W-1:0] DVSR_ONE   = 16'd1;
  localparam logic [DVSR_W-1:0] BLEND_DVSR = 16'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_REPLACE  = 3'd0,
    MODE_SCALE    = 3'd1,
    MODE_ADD      = 3'd2,
    MODE_BLEND    = 3'd3,
    MODE_CONTRAST = 3'd4,
    MODE_INVERT   = 3'd5
  } rppo_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE       = 4'd0,
    CFG_USE_EXCEPT    = 4'd1,
    CFG_EXCEPT_COLOR  = 4'd2,
    CFG_KEY_COLOR     = 4'd3,
    CFG_REPLACE_COLOR = 4'd4,
    CFG_FACTOR        = 4'd5,
    CFG_DIVISOR       = 4'd6,
    CFG_ADD_AMOUNT    = 4'd7
  } rppo_cfg_e;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rppo_pix_t;
  typedef logic [NUM_CHAN-1:0][PROD_W-1:0] rppo_prod_t;

  typedef struct packed {
    logic [MODE_W-1:0]       op_mode;
    logic                    use_except;
    logic [PIX_W-1:0]        except_color;
    logic [PIX_W-1:0]        key_color;
    logic [PIX_W-1:0]        replace_color;
    logic [FACTOR_W-1:0]     factor;
    logic [DVSR_W-1:0]       divisor;
    logic signed [ADD_W-1:0] add_amount;
  } rppo_cfg_t;

  localparam rppo_cfg_t CFG_RESET = '{
    op_mode:       MODE_REPLACE,
    use_except:    1'b0,
    except_color:  '0,
    key_color:     '0,
    replace_color: '0,
    factor:        16'd255,
    divisor:       16'd1,
    add_amount:    '0
  };

  // Side data that rides along with each pixel through the pipeline.
  typedef struct packed {
    logic                use_div;
    logic                add_base;
    logic [NUM_CHAN-1:0] neg;
    rppo_pix_t           pix;
  } rppo_side_t;

  // Working word of one restoring divider lane: partial remainder, and the
  // dividend bits still to shift out with quotient bits filling in below.
  typedef struct packed {
    logic [DVSR_W-1:0] rem;
    logic [PROD_W-1:0] acc;
  } rppo_div_t;

  function automatic rppo_div_t rppo_div_step(rppo_div_t cur, logic [DVSR_W-1:0] dvsr);
    rppo_div_t   nxt;
    logic [DVSR_W:0] trial;
    logic [DVSR_W:0] diff;
    trial   = {cur.rem, cur.acc[PROD_W-1]};
    diff    = trial - {1'b0, dvsr};
    // The remainder stays below the divisor, so the top bit of the
    // difference is set exactly when the trial is below the divisor.
    nxt.acc = {cur.acc[PROD_W-2:0], ~diff[DVSR_W]};
    nxt.rem = diff[DVSR_W] ? trial[DVSR_W-1:0] : diff[DVSR_W-1:0];
    return nxt;
  endfunction

endpackage

// ===== rtl/rppo_prep.sv =====
// First pipeline stage: mode decode, direct results and multiplier operands.
module rppo_prep
  import rppo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rppo_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rppo_pix_t  pixel_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rppo_side_t out_side_o,
  output rppo_pix_t  out_opnd_o
);

  logic       valid_q;
  logic       ready;
  rppo_side_t side_d, side_q;
  rppo_pix_t  opnd_d, opnd_q;

  logic        except_hit;
  logic        key_hit;
  rppo_pix_t   chan_k;
  rppo_pix_t   mag;
  rppo_pix_t   sum_add;
  logic [NUM_CHAN-1:0] k_lt;

  always_comb begin
    except_hit = cfg_i.use_except && (pixel_i == cfg_i.except_color);
    key_hit    = (pixel_i == cfg_i.key_color);
    chan_k     = cfg_i.key_color;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      k_lt[ch]    = chan_k[ch] < pixel_i[ch];
      mag[ch]     = k_lt[ch] ? (pixel_i[ch] - chan_k[ch]) : (chan_k[ch] - pixel_i[ch]);
      // Only the low byte of the sum is kept, so the offset's low byte suffices.
      sum_add[ch] = pixel_i[ch] + cfg_i.add_amount[CHAN_W-1:0];
    end
  end

  always_comb begin
    side_d.use_div  = 1'b0;
    side_d.add_base = 1'b1;
    side_d.neg      = '0;
    side_d.pix      = pixel_i;
    opnd_d          = '0;
    case (cfg_i.op_mode)
      MODE_REPLACE: begin
        side_d.pix = key_hit ? cfg_i.replace_color : pixel_i;
      end
      MODE_SCALE: begin
        side_d.use_div  = 1'b1;
        side_d.add_base = 1'b0;
        opnd_d          = pixel_i;
      end
      MODE_ADD: begin
        side_d.pix = sum_add;
      end
      MODE_BLEND: begin
        side_d.use_div = 1'b1;
        side_d.neg     = k_lt;
        opnd_d         = mag;
      end
      MODE_CONTRAST: begin
        side_d.use_div = 1'b1;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          opnd_d[ch] = CHAN_MAX - mag[ch];
        end
      end
      MODE_INVERT: begin
        side_d.pix = ~pixel_i;
      end
      default: begin
        side_d.pix = pixel_i;
      end
    endcase
    if (except_hit) begin
      side_d.use_div = 1'b0;
      side_d.pix     = pixel_i;
    end
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      side_q <= side_d;
      opnd_q <= opnd_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_side_o  = side_q;
  assign out_opnd_o  = opnd_q;

endmodule

// ===== rtl/rppo_mult.sv =====
// Second pipeline stage: one 8 by 16 bit multiply per channel.
module rppo_mult
  import rppo_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [FACTOR_W-1:0] factor_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rppo_side_t          in_side_i,
  input  rppo_pix_t           in_opnd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rppo_side_t          out_side_o,
  output rppo_prod_t          out_prod_o
);

  logic       valid_q;
  logic       ready;
  rppo_side_t side_q;
  rppo_prod_t prod_d, prod_q;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      prod_d[ch] = PROD_W'(in_opnd_i[ch]) * PROD_W'(factor_i);
    end
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      side_q <= in_side_i;
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_side_o  = side_q;
  assign out_prod_o  = prod_q;

endmodule

// ===== rtl/rppo_div.sv =====
// Pipelined restoring divider, two quotient bits per stage, three channel lanes.
module rppo_div
  import rppo_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DVSR_W-1:0] dvsr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rppo_side_t        in_side_i,
  input  rppo_prod_t        in_prod_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rppo_side_t        out_side_o,
  output rppo_prod_t        out_quot_o
);

  logic       vld_q  [DIV_STAGES];
  rppo_side_t side_q [DIV_STAGES];
  rppo_div_t  work_q [DIV_STAGES][NUM_CHAN];
  logic       rdy    [DIV_STAGES+1];

  assign rdy[DIV_STAGES] = out_ready_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic       src_vld;
    rppo_side_t src_side;
    rppo_div_t  src  [NUM_CHAN];
    rppo_div_t  nxt  [NUM_CHAN];

    if (s == 0) begin : g_first
      assign src_vld  = in_valid_i;
      assign src_side = in_side_i;
      for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
        assign src[ch] = '{rem: '0, acc: in_prod_i[ch]};
      end
    end else begin : g_rest
      assign src_vld  = vld_q[s-1];
      assign src_side = side_q[s-1];
      for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
        assign src[ch] = work_q[s-1][ch];
      end
    end

    always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        nxt[ch] = src[ch];
        for (int b = 0; b < DIV_BITS; b++) begin
          nxt[ch] = rppo_div_step(nxt[ch], dvsr_i);
        end
      end
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_vld) begin
        side_q[s] <= src_side;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          work_q[s][ch] <= nxt[ch];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign out_side_o  = side_q[DIV_STAGES-1];

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      out_quot_o[ch] = work_q[DIV_STAGES-1][ch].acc;
    end
  end

endmodule

// ===== rtl/rppo_post.sv =====
// Last pipeline stage: applies the quotient to each channel and holds the output beat.
module rppo_post
  import rppo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rppo_side_t in_side_i,
  input  rppo_prod_t in_quot_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rppo_pix_t  out_pixel_o
);

  logic      valid_q;
  logic      ready;
  rppo_pix_t pix_d, pix_q;
  rppo_pix_t quot8;
  rppo_pix_t adj;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      quot8[ch] = in_quot_i[ch][CHAN_W-1:0];
      // Blend moves toward the key from above when the key is smaller.
      adj[ch]   = in_side_i.neg[ch] ? CHAN_W'(8'd0 - quot8[ch]) : quot8[ch];
      if (!in_side_i.use_div) begin
        pix_d[ch] = in_side_i.pix[ch];
      end else if (in_side_i.add_base) begin
        pix_d[ch] = in_side_i.pix[ch] + adj[ch];
      end else begin
        pix_d[ch] = quot8[ch];
      end
    end
  end

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pixel_o = pix_q;

endmodule

// ===== rtl/rgb_pixel_point_operation_core.sv =====
// Top level of the RGB pixel point operation core: register file and pipeline.
//
// The core applies one per-pixel operation, chosen by the mode register, to a
// stream of packed 24-bit pixels (red in bits 7:0, green in 15:8, blue in
// 23:16): color replace, scale by factor/divisor, signed add, blend toward the
// key color, contrast raise, or invert. Every channel result keeps only its low
// eight bits, with no saturation. When except keying is on, a pixel equal to
// the except color passes through unchanged. The core takes one beat per clock
// cycle while the output is not stalled. Its pipeline has one stage for mode
// decode, one for the 8 by 16 bit multiply, twelve for the restoring divider
// (two quotient bits per stage, which also serves the divide by 255 of blend
// and contrast), and the output register. Stalls ripple back stage by stage,
// so empty stages fill while the output is held and the input keeps taking
// beats until the pipeline is full. Configuration writes are always accepted
// (cfg_ready_o is tied high); the registers must only be written while no
// pixel is in flight. Indexes 8 and up are ignored.
module rgb_pixel_point_operation_core
  import rppo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  // Pixel output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  rppo_cfg_t         cfg_q;
  logic [DVSR_W-1:0] dvsr;

  // Register file. Written values are truncated to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_OP_MODE:       cfg_q.op_mode       <= cfg_data_i[MODE_W-1:0];
        CFG_USE_EXCEPT:    cfg_q.use_except    <= cfg_data_i[0];
        CFG_EXCEPT_COLOR:  cfg_q.except_color  <= cfg_data_i[PIX_W-1:0];
        CFG_KEY_COLOR:     cfg_q.key_color     <= cfg_data_i[PIX_W-1:0];
        CFG_REPLACE_COLOR: cfg_q.replace_color <= cfg_data_i[PIX_W-1:0];
        CFG_FACTOR:        cfg_q.factor        <= cfg_data_i[FACTOR_W-1:0];
        CFG_DIVISOR:       cfg_q.divisor       <= cfg_data_i[DVSR_W-1:0];
        CFG_ADD_AMOUNT:    cfg_q.add_amount    <= $signed(cfg_data_i[ADD_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // The divider sees the scale divisor in scale mode (zero counts as one) and
  // 255 otherwise. The user must keep configuration static while pixels are in
  // flight (the core does not enforce it), so every divider stage can read it directly.
  always_comb begin
    if (cfg_q.op_mode == MODE_SCALE) begin
      dvsr = (cfg_q.divisor == '0) ? DVSR_ONE : cfg_q.divisor;
    end else begin
      dvsr = BLEND_DVSR;
    end
  end

  logic       prep_ready;
  logic       prep_valid;
  rppo_side_t prep_side;
  rppo_pix_t  prep_opnd;

  logic       mult_ready;
  logic       mult_valid;
  rppo_side_t mult_side;
  rppo_prod_t mult_prod;

  logic       div_ready;
  logic       div_valid;
  rppo_side_t div_side;
  rppo_prod_t div_quot;

  logic       post_ready;
  rppo_pix_t  post_pixel;

  rppo_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (prep_ready),
    .pixel_i     (pixel_in_i),
    .out_valid_o (prep_valid),
    .out_ready_i (mult_ready),
    .out_side_o  (prep_side),
    .out_opnd_o  (prep_opnd)
  );

  rppo_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .factor_i    (cfg_q.factor),
    .in_valid_i  (prep_valid),
    .in_ready_o  (mult_ready),
    .in_side_i   (prep_side),
    .in_opnd_i   (prep_opnd),
    .out_valid_o (mult_valid),
    .out_ready_i (div_ready),
    .out_side_o  (mult_side),
    .out_prod_o  (mult_prod)
  );

  rppo_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dvsr_i      (dvsr),
    .in_valid_i  (mult_valid),
    .in_ready_o  (div_ready),
    .in_side_i   (mult_side),
    .in_prod_i   (mult_prod),
    .out_valid_o (div_valid),
    .out_ready_i (post_ready),
    .out_side_o  (div_side),
    .out_quot_o  (div_quot)
  );

  rppo_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (post_ready),
    .in_side_i   (div_side),
    .in_quot_i   (div_quot),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_pixel_o (post_pixel)
  );

  assign in_stall_o  = !prep_ready;
  assign pixel_out_o = post_pixel;

endmodule

// ===== rtl/rppo_checker.sv =====
// Port-level checker of the pixel point operation core and its bind statement.
`include "rgb_pixel_point_operation_core_defines.svh"

module rppo_checker
  import rppo_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] pixel_out_i,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i
);

  // A held output beat keeps its data.
  `RPPO_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(pixel_out_i))

  // An output beat only goes away after it was taken.
  `RPPO_ASSERT_IMP(a_out_taken, $fell(out_valid_i), $past(!out_stall_i))

  // With the output register empty, every stage can move, so input is never stalled.
  `RPPO_ASSERT_IMP(a_no_stall_empty, !out_valid_i, !in_stall_i)

  // Configuration writes are never refused.
  `RPPO_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_i)

endmodule

bind rgb_pixel_point_operation_core rppo_checker u_rppo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_i (pixel_out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

// ===== bench/rgb_pixel_point_operation_core_test.sv =====
// Testbench for the RGB pixel point operation core, checked against its own pixel predictor.
`timescale 1ns / 100ps

module rgb_pixel_point_operation_core_test
  import rppo_pkg::*;
();

  // Mode codes that the package leaves unnamed; the core passes pixels through for both.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  // First register index past the end of the register file; writes there are dropped.
  localparam int unsigned CFG_IDX_FIRST_UNUSED = int'(CFG_ADD_AMOUNT) + 1;
  localparam int unsigned CFG_IDX_LAST = (1 << CFG_IDX_W) - 1;
  // Pipeline depth given in the core's header; used for the settle time at the end.
  localparam int unsigned PIPE_DEPTH = 15;
  localparam int unsigned MAX_REPORTS = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the register file, updated at each accepted write beat.
  logic [MODE_W-1:0]   cfg_mode = MODE_REPLACE;
  logic                cfg_except_on = 1'b0;
  logic [PIX_W-1:0]    cfg_except_pix = '0;
  logic [PIX_W-1:0]    cfg_key_pix = '0;
  logic [PIX_W-1:0]    cfg_repl_pix = '0;
  logic [FACTOR_W-1:0] cfg_factor = 16'd255;
  logic [DVSR_W-1:0]   cfg_divisor = 16'd1;
  logic [ADD_W-1:0]    cfg_add = '0;

  // Pixels the core still owes us, oldest first.
  logic [PIX_W-1:0] owed_pixels[$];

  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned mismatches = 0;

  rgb_pixel_point_operation_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random, at a rate set per phase of the run.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Computes the pixel the core should return for one input pixel under the
  // current register settings. Each channel is worked in signed 32-bit
  // arithmetic, which holds every product, and then wrapped to eight bits.
  function automatic logic [PIX_W-1:0] transform_pixel(logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] res;
    int chan;
    int key;
    int weight;
    int span;
    int val;
    res = px;
    weight = int'(cfg_factor);
    if (cfg_except_on && px == cfg_except_pix) begin
      res = px;
    end else if (cfg_mode == MODE_REPLACE) begin
      res = (px == cfg_key_pix) ? cfg_repl_pix : px;
    end else if (cfg_mode <= MODE_INVERT) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        chan = int'(px[CHAN_W*i +: CHAN_W]);
        key = int'(cfg_key_pix[CHAN_W*i +: CHAN_W]);
        case (cfg_mode)
          MODE_SCALE: begin
            // A zero divisor behaves as a divisor of one.
            val = (chan * weight) / ((cfg_divisor == '0) ? 1 : int'(cfg_divisor));
          end
          MODE_ADD: begin
            val = chan + int'($signed(cfg_add));
          end
          MODE_BLEND: begin
            // SystemVerilog division truncates toward zero, as the blend needs.
            val = chan + ((key - chan) * weight) / 255;
          end
          MODE_CONTRAST: begin
            span = (key > chan) ? key - chan : chan - key;
            val = chan + ((255 - span) * weight) / 255;
          end
          default: begin
            val = 255 - chan;
          end
        endcase
        res[CHAN_W*i +: CHAN_W] = val[CHAN_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic note_failure(input string what, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected %06h, got %06h", $realtime, what, want, got);
    end
  endtask

  // Each result beat is checked against the oldest owed pixel.
  always @(posedge clk_i) begin : check_results
    logic [PIX_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_pixels.size() == 0) begin
        note_failure("result with nothing owed", '0, pixel_out_o);
      end else begin
        want = owed_pixels.pop_front();
        if (pixel_out_o !== want) begin
          note_failure("pixel mismatch", want, pixel_out_o);
        end
      end
    end
  end

  // One write beat on the register channel. The valid is dropped for a cycle
  // afterward so that back-to-back writes never assign it twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_OP_MODE:       cfg_mode = data[MODE_W-1:0];
      CFG_USE_EXCEPT:    cfg_except_on = data[0];
      CFG_EXCEPT_COLOR:  cfg_except_pix = data[PIX_W-1:0];
      CFG_KEY_COLOR:     cfg_key_pix = data[PIX_W-1:0];
      CFG_REPLACE_COLOR: cfg_repl_pix = data[PIX_W-1:0];
      CFG_FACTOR:        cfg_factor = data[FACTOR_W-1:0];
      CFG_DIVISOR:       cfg_divisor = data[DVSR_W-1:0];
      CFG_ADD_AMOUNT:    cfg_add = data[ADD_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one pixel beat, with random idle cycles ahead of it. The valid is
  // left high after acceptance so a following beat can go out without a gap.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    owed_pixels.push_back(transform_pixel(px));
  endtask

  // Holds the sender off until every owed pixel has come back. Register
  // writes are only made after this, while nothing is in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (owed_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    // Replace mode with key and replacement both black: black stays black.
    send_pixel('0);
    send_pixel(24'h123456);
    wait_idle();
  endtask

  task automatic test_replace();
    write_reg(CFG_KEY_COLOR, 24'h0A0B0C);
    write_reg(CFG_REPLACE_COLOR, 24'hFFFFFF);
    send_pixel(24'h0A0B0C);
    send_pixel(24'h0A0B0D);
    wait_idle();
  endtask

  task automatic test_scale();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_SCALE));
    write_reg(CFG_FACTOR, 24'h00FFFF);
    write_reg(CFG_DIVISOR, CFG_DATA_W'(DVSR_ONE));
    // Full-scale product wraps to its low eight bits.
    send_pixel(24'hFFFFFF);
    wait_idle();
    // A zero divisor must act as one.
    write_reg(CFG_FACTOR, 24'd3);
    write_reg(CFG_DIVISOR, '0);
    send_pixel(24'h80807F);
    wait_idle();
    write_reg(CFG_FACTOR, 24'd255);
    write_reg(CFG_DIVISOR, 24'h00FFFF);
    send_pixel(24'h01FF80);
    wait_idle();
  endtask

  task automatic test_add();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_ADD));
    write_reg(CFG_ADD_AMOUNT, 24'd255);
    send_pixel(24'hFFFFFF);
    wait_idle();
    // Negative offsets wrap below zero; the most negative code is tried too.
    write_reg(CFG_ADD_AMOUNT, 24'h000101);
    send_pixel(24'h000000);
    wait_idle();
    write_reg(CFG_ADD_AMOUNT, 24'h000100);
    send_pixel(24'h7F80FF);
    wait_idle();
  endtask

  task automatic test_blend();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_BLEND));
    write_reg(CFG_KEY_COLOR, 24'hFF0000);
    write_reg(CFG_FACTOR, 24'd255);
    send_pixel(24'h00FF80);
    wait_idle();
    // An oversized weight overshoots the key in both directions.
    write_reg(CFG_FACTOR, 24'h00FFFF);
    send_pixel(24'h102030);
    wait_idle();
  endtask

  task automatic test_contrast();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_CONTRAST));
    write_reg(CFG_KEY_COLOR, 24'h808080);
    send_pixel(24'hFF00FF);
    wait_idle();
    write_reg(CFG_FACTOR, '0);
    send_pixel(24'h445566);
    wait_idle();
  endtask

  task automatic test_invert();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_INVERT));
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    wait_idle();
  endtask

  task automatic test_unused_modes();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_SPARE_LO));
    send_pixel(24'hC3A55A);
    wait_idle();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_SPARE_HI));
    send_pixel(24'h3C5AA5);
    wait_idle();
  endtask

  task automatic test_except_and_bad_index();
    write_reg(CFG_OP_MODE, CFG_DATA_W'(MODE_INVERT));
    write_reg(CFG_EXCEPT_COLOR, 24'hABCDEF);
    write_reg(CFG_USE_EXCEPT, 24'd1);
    send_pixel(24'hABCDEF);
    send_pixel(24'hABCDEE);
    wait_idle();
    // Writes past the last register must leave every setting as it was.
    for (int i = CFG_IDX_FIRST_UNUSED; i <= CFG_IDX_LAST; i++) begin
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom()));
    end
    send_pixel(24'hABCDEF);
    send_pixel(24'h543210);
    wait_idle();
  endtask

  // Loads every register with a random setting, leaning on the extremes.
  task automatic load_random_settings();
    logic [CFG_DATA_W-1:0] val;
    val = ($urandom_range(9) == 0) ?
          CFG_DATA_W'($urandom_range(int'(MODE_SPARE_HI), int'(MODE_SPARE_LO))) :
          CFG_DATA_W'($urandom_range(int'(MODE_INVERT)));
    // Now and then junk rides above the mode bits.
    if ($urandom_range(7) == 0) val[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom());
    write_reg(CFG_OP_MODE, val);
    write_reg(CFG_USE_EXCEPT, CFG_DATA_W'($urandom()));
    write_reg(CFG_EXCEPT_COLOR, CFG_DATA_W'($urandom()));
    write_reg(CFG_KEY_COLOR, CFG_DATA_W'($urandom()));
    write_reg(CFG_REPLACE_COLOR, CFG_DATA_W'($urandom()));
    case ($urandom_range(5))
      0: val = '0;
      1: val = 24'd1;
      2: val = 24'd255;
      3: val = 24'hFFFF;
      4: val = 24'($urandom_range(511));
      default: val = CFG_DATA_W'($urandom());
    endcase
    write_reg(CFG_FACTOR, val);
    case ($urandom_range(6))
      0: val = '0;
      1: val = 24'd1;
      2: val = 24'd255;
      3: val = 24'hFFFF;
      4: val = 24'($urandom_range(16, 1));
      default: val = CFG_DATA_W'($urandom());
    endcase
    write_reg(CFG_DIVISOR, val);
    case ($urandom_range(5))
      0: val = 24'h100;
      1: val = 24'h101;
      2: val = 24'h0FF;
      3: val = '0;
      default: val = CFG_DATA_W'($urandom());
    endcase
    write_reg(CFG_ADD_AMOUNT, val);
  endtask

  // Picks a pixel so that the key and except colors, and near misses of
  // them, come up far more often than pure chance would give.
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0, 1: return cfg_key_pix;
      2: return cfg_except_pix;
      3: return cfg_key_pix ^ (24'd1 << $urandom_range(PIX_W - 1));
      4: return cfg_except_pix ^ (24'd1 << $urandom_range(PIX_W - 1));
      5: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      default: return PIX_W'($urandom());
    endcase
  endfunction

  // One phase of random traffic: a run of random settings, each followed by
  // a burst of pixels, with the given idle and stall rates on either side.
  task automatic test_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input int unsigned n_pixels);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    send_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    while (sent < n_pixels) begin
      wait_idle();
      load_random_settings();
      burst = $urandom_range(80, 20);
      for (int i = 0; i < burst; i++) begin
        send_pixel(pick_pixel());
        // Once in a while the sender waits for the pipeline to empty out.
        if ($urandom_range(199) == 0) wait_idle();
      end
      sent += burst;
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks run with both sides free of idling.
    test_reset_state();
    test_replace();
    test_scale();
    test_add();
    test_blend();
    test_contrast();
    test_invert();
    test_unused_modes();
    test_except_and_bad_index();

    // Random traffic under each idling pattern in turn.
    test_random_phase(0, 0, 425);
    test_random_phase(66, 0, 425);
    test_random_phase(0, 66, 425);
    test_random_phase(26, 26, 425);

    out_stall_pct = 0;
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (mismatches == 0 && owed_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
